### hw/rtl/mprc_pkg.sv
// shared types, constants and register codes for the med predictive residual coder
`timescale 1ns / 1ps
`default_nettype none

package mprc_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = 16;
    localparam int PIX_W        = 8;
    localparam int RES_W        = 9;
    localparam int WIDTH_REG_W  = 13;
    localparam int HEIGHT_REG_W = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_ADDR_W   = 2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef struct packed {
        logic signed [RES_W-1:0] residual;
        logic [PIX_W-1:0]        pixel;
        logic                    end_of_frame;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/med_predictive_residual_coder_unit.sv
// top level of the med predictive residual coder: config, raster counters, neighbors
`timescale 1ns / 1ps
`default_nettype none

// Takes one 8-bit sample (encode) or 9-bit signed residual (decode) per transaction
// in raster order and returns one transaction per input: residual, pixel and an
// end-of-frame flag. Throughput is one item per clock while m_ready is high, and each result
// appears on the m_ side the cycle after its input transaction. A stalled result
// waits in the output register, one more transaction is taken into a skid register,
// and only then does s_ready drop. The previous row lives in a
// 4096 x 8 memory with one write and one registered read port; the read address
// runs one column ahead of the item being taken, with a bypass for one-pixel rows,
// so no clearing pass is needed after reset and the block is ready at once.
// Configuration writes (mode, image_width, image_height) are meant for idle time.
module med_predictive_residual_coder_unit (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic        [mprc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic        [mprc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic        [mprc_pkg::PIX_W-1:0]      s_pixel_in,
    input  wire logic signed [mprc_pkg::RES_W-1:0]      s_residual_in,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed      [mprc_pkg::RES_W-1:0]      m_residual_out,
    output logic             [mprc_pkg::PIX_W-1:0]      m_pixel_out,
    output logic                                        m_end_of_frame
);

    import mprc_pkg::*;

    mode_t                   mode_reg;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [PIX_W-1:0] left_reg;
    logic [PIX_W-1:0] upper_left_reg;

    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic             row_end;
    logic             frame_end;
    logic             accept;

    logic [COL_W-1:0]        rd_addr;
    logic [PIX_W-1:0]        above;
    logic [PIX_W-1:0]        pix;
    logic signed [RES_W-1:0] res;
    result_t                 result;
    result_t                 out_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_ENCODE;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MODE:   mode_reg   <= mode_t'(cfg_wdata[0]);
                CFG_WIDTH:  width_reg  <= cfg_wdata[WIDTH_REG_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_wdata[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // zero width counts as one, oversize width as the line store size
    always_comb begin
        priority if (width_reg == '0) begin
            last_col = '0;
        end else if (32'(width_reg) > MAX_WIDTH) begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end else begin
            last_col = COL_W'(width_reg - WIDTH_REG_W'(1));
        end
    end

    assign last_row  = (height_reg == '0) ? '0 : ROW_W'(height_reg - HEIGHT_REG_W'(1));
    assign row_end   = (col_reg >= last_col);
    assign frame_end = row_end && (row_reg >= last_row);
    assign accept    = s_valid && s_ready;

    always_comb begin
        col_next = row_end ? '0 : col_reg + COL_W'(1);
        priority if (!row_end) begin
            row_next = row_reg;
        end else if (frame_end) begin
            row_next = '0;
        end else begin
            row_next = row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            left_reg       <= '0;
            upper_left_reg <= '0;
        end else if (accept) begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            left_reg       <= pix;
            upper_left_reg <= above;
        end
    end

    // prefetch the upper sample for whichever column comes next
    assign rd_addr = accept ? col_next : col_reg;

    mprc_line_store u_line_store (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (pix),
        .rd_addr (rd_addr),
        .rd_data (above)
    );

    mprc_core u_core (
        .mode         (mode_reg),
        .col_zero     (col_reg == '0),
        .row_zero     (row_reg == '0),
        .left         (left_reg),
        .above        (above),
        .upper_left   (upper_left_reg),
        .pixel_in     (s_pixel_in),
        .residual_in  (s_residual_in),
        .pixel_out    (pix),
        .residual_out (res)
    );

    assign result.residual     = res;
    assign result.pixel        = pix;
    assign result.end_of_frame = frame_end;

    mprc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_residual_out = out_data.residual;
    assign m_pixel_out    = out_data.pixel;
    assign m_end_of_frame = out_data.end_of_frame;

endmodule

`default_nettype wire

### hw/rtl/mprc_line_store.sv
// previous-row sample memory with registered read and write-to-read bypass
`timescale 1ns / 1ps
`default_nettype none

module mprc_line_store (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [mprc_pkg::COL_W-1:0]    wr_addr,
    input  wire logic [mprc_pkg::PIX_W-1:0]    wr_data,
    input  wire logic [mprc_pkg::COL_W-1:0]    rd_addr,
    output logic      [mprc_pkg::PIX_W-1:0]    rd_data
);

    import mprc_pkg::*;

    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_data_reg;
    logic [PIX_W-1:0] fwd_data_reg;
    logic             fwd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    // same-address write and read in one cycle: hand over the new sample
    always_ff @(posedge aclk) begin
        fwd_reg      <= wr_en && (wr_addr == rd_addr);
        fwd_data_reg <= wr_data;
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/mprc_core.sv
// median edge detector prediction with encode and saturating decode
`timescale 1ns / 1ps
`default_nettype none

module mprc_core (
    input  wire mprc_pkg::mode_t                   mode,
    input  wire logic                              col_zero,
    input  wire logic                              row_zero,
    input  wire logic        [mprc_pkg::PIX_W-1:0] left,
    input  wire logic        [mprc_pkg::PIX_W-1:0] above,
    input  wire logic        [mprc_pkg::PIX_W-1:0] upper_left,
    input  wire logic        [mprc_pkg::PIX_W-1:0] pixel_in,
    input  wire logic signed [mprc_pkg::RES_W-1:0] residual_in,
    output logic             [mprc_pkg::PIX_W-1:0] pixel_out,
    output logic signed      [mprc_pkg::RES_W-1:0] residual_out
);

    import mprc_pkg::*;

    logic [PIX_W-1:0] a, b, c;
    logic [PIX_W-1:0] lo, hi, pred;
    logic [PIX_W-1:0] gradient;
    logic signed [RES_W:0] sum;

    // outside the frame neighbors read as zero
    assign a = col_zero ? '0 : left;
    assign b = row_zero ? '0 : above;
    assign c = (col_zero || row_zero) ? '0 : upper_left;

    assign lo = (a < b) ? a : b;
    assign hi = (a < b) ? b : a;
    // only used when c lies strictly between lo and hi, so it never leaves 0..255
    assign gradient = a + b - c;

    always_comb begin
        priority if (c >= hi) begin
            pred = lo;
        end else if (c <= lo) begin
            pred = hi;
        end else begin
            pred = gradient;
        end
    end

    assign sum = {residual_in[RES_W-1], residual_in} + $signed({2'b00, pred});

    always_comb begin
        unique case (mode)
            MODE_ENCODE: begin
                pixel_out    = pixel_in;
                residual_out = $signed({1'b0, pixel_in}) - $signed({1'b0, pred});
            end
            MODE_DECODE: begin
                residual_out = residual_in;
                priority if (sum[RES_W]) begin
                    pixel_out = '0;
                end else if (sum[RES_W-1]) begin
                    pixel_out = '1;
                end else begin
                    pixel_out = sum[PIX_W-1:0];
                end
            end
            default: begin
                pixel_out    = pixel_in;
                residual_out = residual_in;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/mprc_skid.sv
// output register with skid stage so the input ready is fully registered
`timescale 1ns / 1ps
`default_nettype none

module mprc_skid (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mprc_pkg::result_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mprc_pkg::result_t      out_data
);

    import mprc_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_free;

    assign in_ready = !skid_valid_reg;
    assign out_free = out_ready || !out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        if (!out_free && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### hw/rtl/mprc_checker.sv
// port-level checks for the med predictive residual coder and their bind
`timescale 1ns / 1ps
`default_nettype none

module mprc_checker (
    input wire logic                                   aclk,
    input wire logic                                   aresetn,
    input wire logic                                   s_valid,
    input wire logic                                   s_ready,
    input wire logic                                   m_valid,
    input wire logic                                   m_ready,
    input wire logic signed [mprc_pkg::RES_W-1:0]      m_residual_out,
    input wire logic        [mprc_pkg::PIX_W-1:0]      m_pixel_out,
    input wire logic                                   m_end_of_frame
);

    // after an accepted transaction the output always holds a valid result next cycle
    a_accept_to_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted transaction did not reach output");

    // input stalls only while a result is held at the output
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output");

    // the skid stage only fills behind a stalled output
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("input stalled without output back-pressure");

    a_output_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_residual_out)
            && $stable(m_pixel_out) && $stable(m_end_of_frame)))
        else $error("stalled result changed");

endmodule

bind med_predictive_residual_coder_unit mprc_checker u_mprc_checker (.*);

`default_nettype wire

### verif/testbench.sv
// testbench for the med predictive residual coder: directed cases, random frames, checking
`timescale 1ns / 1ps

module testbench;
    import mprc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int FRAME_CAP   = 120;
    localparam int WIDE_ITEMS  = 48;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr      = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata     = '0;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic [PIX_W-1:0]        s_pixel_in    = '0;
    logic signed [RES_W-1:0] s_residual_in = '0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic signed [RES_W-1:0] m_residual_out;
    logic [PIX_W-1:0]        m_pixel_out;
    logic                    m_end_of_frame;

    med_predictive_residual_coder_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_in     (s_pixel_in),
        .s_residual_in  (s_residual_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_residual_out (m_residual_out),
        .m_pixel_out    (m_pixel_out),
        .m_end_of_frame (m_end_of_frame)
    );

    always #2 aclk = ~aclk;

    // predictor copy of the block's registers and raster state
    mode_t                   cfg_mode   = MODE_ENCODE;
    logic [WIDTH_REG_W-1:0]  cfg_width  = WIDTH_RESET;
    logic [HEIGHT_REG_W-1:0] cfg_height = HEIGHT_RESET;
    logic [PIX_W-1:0]        row_line [MAX_WIDTH];
    int                      col_pos    = 0;
    int                      row_pos    = 0;
    logic [PIX_W-1:0]        left_pix   = '0;
    logic [PIX_W-1:0]        upleft_pix = '0;

    result_t coded_q [$];
    int      items_sent     = 0;
    int      results_seen   = 0;
    int      error_count    = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      quiet_cycles   = 0;

    function automatic int width_in_use(input logic [WIDTH_REG_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(w);
    endfunction

    function automatic int height_in_use(input logic [HEIGHT_REG_W-1:0] h);
        return (h == 0) ? 1 : int'(h);
    endfunction

    // median edge prediction of one sample, then advance the raster state
    function automatic result_t med_code_sample(input logic [PIX_W-1:0] pix_in,
                                                input logic signed [RES_W-1:0] res_in);
        int               a, b, c, lo, hi, pred, res, pix;
        logic [PIX_W-1:0] above;
        result_t          r;
        above = row_line[col_pos];
        a = (col_pos > 0) ? int'(left_pix) : 0;
        b = (row_pos > 0) ? int'(above) : 0;
        c = (col_pos > 0 && row_pos > 0) ? int'(upleft_pix) : 0;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c >= hi)
            pred = lo;
        else if (c <= lo)
            pred = hi;
        else
            pred = a + b - c;
        if (cfg_mode == MODE_ENCODE) begin
            pix = int'(pix_in);
            res = pix - pred;
        end else begin
            res = int'(res_in);
            pix = res + pred;
            if (pix < 0)
                pix = 0;
            if (pix > 255)
                pix = 255;
        end
        row_line[col_pos] = pix[PIX_W-1:0];
        upleft_pix = above;
        left_pix = pix[PIX_W-1:0];
        r.residual = res[RES_W-1:0];
        r.pixel = pix[PIX_W-1:0];
        r.end_of_frame = 1'b0;
        if (col_pos >= width_in_use(cfg_width) - 1) begin
            col_pos = 0;
            if (row_pos >= height_in_use(cfg_height) - 1) begin
                row_pos = 0;
                r.end_of_frame = 1'b1;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
        return r;
    endfunction

    // predicts each accepted input transaction and checks each output transaction
    always @(posedge aclk) begin : check_results
        result_t want;
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn) begin
            if (s_valid && s_ready)
                coded_q.push_back(med_code_sample(s_pixel_in, s_residual_in));
            if (m_valid && m_ready) begin
                results_seen++;
                if (coded_q.size() == 0) begin
                    $display("%0t unexpected result: residual %0d pixel %0d eof %0b", $time,
                             m_residual_out, m_pixel_out, m_end_of_frame);
                    error_count++;
                end else begin
                    want = coded_q.pop_front();
                    if (m_residual_out !== want.residual) begin
                        $display("%0t residual_out: expected %0d, actual %0d", $time,
                                 want.residual, m_residual_out);
                        error_count++;
                    end
                    if (m_pixel_out !== want.pixel) begin
                        $display("%0t pixel_out: expected %0d, actual %0d", $time,
                                 want.pixel, m_pixel_out);
                        error_count++;
                    end
                    if (m_end_of_frame !== want.end_of_frame) begin
                        $display("%0t end_of_frame: expected %0b, actual %0b", $time,
                                 want.end_of_frame, m_end_of_frame);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_sample(input logic [PIX_W-1:0] pix, input logic signed [RES_W-1:0] res);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_in    <= pix;
        s_residual_in <= res;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_random_sample();
        logic [PIX_W-1:0]        pix;
        logic signed [RES_W-1:0] res;
        case ($urandom_range(7))
            0: pix = '0;
            1: pix = '1;
            default: pix = PIX_W'($urandom_range(255));
        endcase
        case ($urandom_range(7))
            0: res = RES_W'($urandom_range(511));
            1: res = 9'h100;
            2: res = 9'h0FF;
            default: res = RES_W'(int'($urandom_range(40)) - 20);
        endcase
        send_sample(pix, res);
    endtask

    // stop sending and wait until every transaction has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (results_seen < items_sent)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_config(input mode_t m, input logic [WIDTH_REG_W-1:0] w,
                                input logic [HEIGHT_REG_W-1:0] h);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_MODE;
        cfg_wdata <= CFG_DATA_W'(m);
        @(posedge aclk);
        cfg_addr  <= CFG_WIDTH;
        cfg_wdata <= CFG_DATA_W'(w);
        @(posedge aclk);
        cfg_addr  <= CFG_HEIGHT;
        cfg_wdata <= CFG_DATA_W'(h);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_mode   = m;
        cfg_width  = w;
        cfg_height = h;
        @(posedge aclk);
    endtask

    // close any open frame with a one-pixel geometry, so widening never reads stale rows
    task automatic start_frame(input mode_t m, input logic [WIDTH_REG_W-1:0] w,
                               input logic [HEIGHT_REG_W-1:0] h);
        drain();
        if (col_pos != 0 || row_pos != 0) begin
            write_config(cfg_mode, 13'd1, 16'd1);
            send_random_sample();
            drain();
        end
        write_config(m, w, h);
    endtask

    task automatic test_reset_defaults();
        send_sample(8'd0, RES_W'($urandom_range(511)));
        send_sample(8'd255, RES_W'($urandom_range(511)));
        send_sample(8'd1, RES_W'($urandom_range(511)));
        send_sample(8'd128, RES_W'($urandom_range(511)));
        drain();
    endtask

    task automatic test_degenerate_geometry();
        start_frame(MODE_ENCODE, 13'd1, 16'd1);
        send_sample(8'd77, 9'h000);
        // zero width and height behave as one
        start_frame(MODE_DECODE, 13'd0, 16'd0);
        send_sample(8'd0, 9'h0FF);
        send_sample(8'd255, 9'h100);
        drain();
    endtask

    task automatic test_med_branches();
        start_frame(MODE_ENCODE, 13'd4, 16'd2);
        send_sample(8'd100, 9'h000);
        send_sample(8'd120, 9'h000);
        send_sample(8'd200, 9'h000);
        send_sample(8'd60, 9'h000);
        send_sample(8'd50, 9'h000);
        send_sample(8'd90, 9'h000);
        send_sample(8'd0, 9'h000);
        send_sample(8'd255, 9'h000);
        drain();
    endtask

    task automatic test_decode_saturation();
        start_frame(MODE_DECODE, 13'd3, 16'd2);
        send_sample(8'hFF, 9'h0FF);
        send_sample(8'h00, 9'h100);
        send_sample(8'hA5, 9'h0C8);
        send_sample(8'h5A, 9'h101);
        send_sample(8'hFF, 9'h064);
        send_sample(8'h00, 9'h000);
        drain();
    endtask

    task automatic test_mode_switch_mid_frame();
        start_frame(MODE_ENCODE, 13'd3, 16'd2);
        send_sample(8'd10, 9'h1F0);
        send_sample(8'd240, 9'h00F);
        send_sample(8'd30, 9'h1FF);
        drain();
        write_config(MODE_DECODE, 13'd3, 16'd2);
        send_sample(8'd0, 9'h1F6);
        send_sample(8'd0, 9'h014);
        send_sample(8'd0, 9'h180);
        drain();
    endtask

    task automatic test_geometry_shrink_mid_frame();
        int k;
        start_frame(MODE_ENCODE, 13'd6, 16'hFFFF);
        for (k = 0; k < 8; k++)
            send_random_sample();
        drain();
        // column already past the new limit and row already on the last row: row and frame end on the next sample
        write_config(MODE_ENCODE, 13'd2, 16'd2);
        for (k = 0; k < 3; k++)
            send_random_sample();
        drain();
    endtask

    // oversize and full widths keep the row open over the first samples
    task automatic test_widest_rows();
        int k;
        start_frame(MODE_ENCODE, 13'h1FFF, 16'd2);
        for (k = 0; k < WIDE_ITEMS; k++)
            send_random_sample();
        start_frame(MODE_DECODE, 13'd4096, 16'd1);
        for (k = 0; k < WIDE_ITEMS; k++)
            send_random_sample();
        drain();
    endtask

    task automatic test_random_frames(input int n_items, input int idle_pct, input int stall_pct);
        int                      sent, n, split, k;
        mode_t                   m;
        logic [WIDTH_REG_W-1:0]  w;
        logic [HEIGHT_REG_W-1:0] h;
        drain();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            m = mode_t'($urandom_range(1));
            case ($urandom_range(9))
                0: w = WIDTH_REG_W'($urandom_range(80));
                1: w = WIDTH_REG_W'($urandom_range(8191));
                default: w = WIDTH_REG_W'($urandom_range(1, 10));
            endcase
            case ($urandom_range(9))
                0: h = '0;
                1: h = HEIGHT_REG_W'($urandom_range(65535));
                default: h = HEIGHT_REG_W'($urandom_range(1, 5));
            endcase
            start_frame(m, w, h);
            n = width_in_use(w) * height_in_use(h);
            if (n > FRAME_CAP)
                n = FRAME_CAP;
            if ($urandom_range(4) == 0)
                n = $urandom_range(1, n);
            split = ($urandom_range(5) == 0) ? $urandom_range(1, n) : 0;
            for (k = 0; k < n; k++) begin
                if (split != 0 && k == split) begin
                    drain();
                    if ($urandom_range(1)) begin
                        m = (m == MODE_ENCODE) ? MODE_DECODE : MODE_ENCODE;
                        write_config(m, cfg_width, cfg_height);
                    end else begin
                        // only narrow mid-frame so every upper neighbor has been written
                        write_config(m, WIDTH_REG_W'($urandom_range(cfg_width)),
                                     HEIGHT_REG_W'($urandom_range(6)));
                    end
                end
                send_random_sample();
            end
            sent += n;
        end
        drain();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_degenerate_geometry();
        test_med_branches();
        test_decode_saturation();
        test_mode_switch_mid_frame();
        test_geometry_shrink_mid_frame();
        test_widest_rows();
        test_random_frames(250, 0, 0);
        test_random_frames(250, 82, 0);
        test_random_frames(250, 0, 82);
        test_random_frames(250, 11, 11);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain();
        repeat (8) @(posedge aclk);
        if (error_count == 0 && coded_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/mprc_pkg.sv
hw/rtl/mprc_line_store.sv
hw/rtl/mprc_core.sv
hw/rtl/mprc_skid.sv
hw/rtl/med_predictive_residual_coder_unit.sv
hw/rtl/mprc_checker.sv
verif/testbench.sv
